// ----- sv/ray_sphere_intersect_unit_macros.svh -----
// Assertion macros shared by the ray-sphere intersection RTL.
// Included by any file that checks its own pipeline behavior.
`ifndef RAY_SPHERE_INTERSECT_UNIT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define RSI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray sphere intersect: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define RSI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray sphere intersect: next-cycle check failed");
`else
`define RSI_ASSERT_IMP(label, clk, rst, ante, cons)
`define RSI_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/rsi_pkg.sv -----
// Shared widths and constants for the ray-sphere intersection block.
// No dependencies; imported by rsi_ifs, rsi_norm and ray_sphere_intersect_unit.
package rsi_pkg;

  // Field widths of the ports.
  localparam int COORD_W  = 32;
  localparam int DIST_W   = 31;
  localparam int RADIUS_W = 25;

  // Internal datapath widths.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SUMSQ_W = 2 * COORD_W;
  localparam int LEN_W   = SUMSQ_W / 2;
  localparam int LSQ_W   = 2 * DIFF_W;
  localparam int LL_W    = LSQ_W + 2;
  localparam int TCA_W   = 36;
  localparam int ARG_W   = 2 * TCA_W;
  localparam int R2_W    = 2 * RADIUS_W;

  // Largest reportable hit distance.
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

// ----- sv/rsi_ifs.sv -----
// Channel interfaces of the ray-sphere intersection block: ray beats,
// result beats and radius writes. Depends on rsi_pkg.

// Ray query channel.
interface rsi_ray_if;
  import rsi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [COORD_W-1:0] heading_x;
  logic signed [COORD_W-1:0] heading_y;
  logic signed [COORD_W-1:0] heading_z;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [DIST_W-1:0]         reach_limit;
  modport source (output valid, origin_x, origin_y, origin_z, heading_x, heading_y,
                  heading_z, center_x, center_y, center_z, reach_limit, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, heading_x, heading_y,
                heading_z, center_x, center_y, center_z, reach_limit, output ready);
endinterface

// Hit result channel.
interface rsi_hit_if;
  import rsi_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] hit_distance;
  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

// Radius register write channel.
interface rsi_cfg_if;
  import rsi_pkg::*;
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] sphere_radius;
  modport source (output valid, sphere_radius, input ready);
  modport sink (input valid, sphere_radius, output ready);
endinterface

// ----- sv/rsi_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries a side payload alongside. Depends on nothing but its parameters.
module rsi_isqrt #(
  parameter int IN_W  = 64,
  parameter int PAY_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [PAY_W-1:0]    in_pay,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [PAY_W-1:0]    out_pay
);
  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic             vld_q  [OUT_W];
  logic [REM_W-1:0] rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];
  logic [IN_W-1:0]  rad_q  [OUT_W];
  logic [PAY_W-1:0] pay_q  [OUT_W];

  for (genvar i = 0; i < OUT_W; i++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  rad_in;
    logic [PAY_W-1:0] pay_in;
    logic [TRY_W-1:0] rem_t;
    logic [TRY_W-1:0] trial;
    logic             take;

    // The first stage starts from the raw radicand with a zero remainder.
    if (i == 0) begin : g_head
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign pay_in  = in_pay;
    end else begin : g_body
      assign v_in    = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign pay_in  = pay_q[i-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_t = {rem_in, rad_in[IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= take ? REM_W'(rem_t - trial) : rem_t[REM_W-1:0];
        root_q[i] <= {root_in[OUT_W-2:0], take};
        rad_q[i]  <= {rad_in[IN_W-3:0], 2'b00};
        pay_q[i]  <= pay_in;
      end
    end
  end

  assign out_valid = vld_q[OUT_W-1];
  assign root      = root_q[OUT_W-1];
  assign out_pay   = pay_q[OUT_W-1];

endmodule

// ----- sv/rsi_norm.sv -----
// Pipelined direction normalizer: three restoring dividers, one quotient
// bit per stage, giving heading * 2^F / len truncated toward zero. Uses rsi_pkg.
module rsi_norm #(
  parameter int F     = 16,
  parameter int PAY_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [rsi_pkg::LEN_W-1:0]             len,
  input  logic [2:0][rsi_pkg::COORD_W-1:0]      hmag,
  input  logic [2:0]                            hneg,
  input  logic [PAY_W-1:0]                      in_pay,
  output logic                                  out_valid,
  output logic signed [F+1:0]                   dir [3],
  output logic [PAY_W-1:0]                      out_pay
);
  import rsi_pkg::*;

  localparam int NS = F + 1;

  logic             vld_q [NS];
  logic [LEN_W-1:0] len_q [NS];
  logic [2:0]       neg_q [NS];
  logic [PAY_W-1:0] pay_q [NS];
  logic [LEN_W-1:0] rem_q [NS][3];
  logic [F:0]       quo_q [NS][3];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic             v_in;
    logic [LEN_W-1:0] len_in;
    logic [2:0]       neg_in;
    logic [PAY_W-1:0] pay_in;

    if (k == 0) begin : g_head
      assign v_in   = in_valid;
      assign len_in = len;
      assign neg_in = hneg;
      assign pay_in = in_pay;
    end else begin : g_body
      assign v_in   = vld_q[k-1];
      assign len_in = len_q[k-1];
      assign neg_in = neg_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [LEN_W:0] part;
      logic [F:0]     quo_in;
      logic           take;

      // The integer part goes first; later stages shift in zero fraction bits.
      if (k == 0) begin : g_head
        assign part   = {1'b0, hmag[j]};
        assign quo_in = '0;
      end else begin : g_body
        assign part   = {rem_q[k-1][j], 1'b0};
        assign quo_in = quo_q[k-1][j];
      end

      assign take = part >= {1'b0, len_in};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k][j] <= take ? LEN_W'(part - {1'b0, len_in}) : part[LEN_W-1:0];
          quo_q[k][j] <= {quo_in[F-1:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_q[k] <= len_in;
        neg_q[k] <= neg_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  // Apply the heading sign to the magnitude quotient.
  for (genvar j = 0; j < 3; j++) begin : g_out
    assign dir[j] = neg_q[NS-1][j] ? -$signed({1'b0, quo_q[NS-1][j]})
                                   : $signed({1'b0, quo_q[NS-1][j]});
  end

  assign out_valid = vld_q[NS-1];
  assign out_pay   = pay_q[NS-1];

endmodule

// ----- sv/ray_sphere_intersect_unit.sv -----
// Ray against sphere intersection in signed fixed point, fully pipelined.
// Its depth is set by the two bit-per-stage square roots and the
// bit-per-stage normalizing dividers. Throughput: one beat per cycle while
// the output is not stalled.
// A stalled output holds the whole pipeline. Reset empties the pipeline and
// loads the radius register with 0.6; uses rsi_pkg, rsi_ifs, rsi_isqrt, rsi_norm.
`include "ray_sphere_intersect_unit_macros.svh"
module ray_sphere_intersect_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  rsi_ray_if.sink  ray,
  rsi_hit_if.source result,
  rsi_cfg_if.sink  cfg
);
  import rsi_pkg::*;

  localparam int PROD_W = DIFF_W + FRAC_BITS + 2;
  localparam int PROJ_W = PROD_W + 2;
  localparam logic [LEN_W-1:0] MIN_LEN =
    LEN_W'((2 ** FRAC_BITS + 9999) / 10000);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET =
    RADIUS_W'((6 * 2 ** FRAC_BITS + 5) / 10);

  typedef struct packed {
    logic [2:0][DIFF_W-1:0]  l;
    logic [2:0][COORD_W-1:0] hmag;
    logic [2:0]              hneg;
    logic [DIST_W-1:0]       lim;
  } front_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] l;
    logic [DIST_W-1:0]      lim;
    logic                   short_dir;
  } mid_t;

  typedef struct packed {
    logic [TCA_W-1:0]  tca;
    logic              noline;
    logic [DIST_W-1:0] lim;
  } back_t;

  logic en;

  // Radius register; the user must make writes arrive only while the pipeline is empty, as the block has no check.
  logic [RADIUS_W-1:0] radius;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.sphere_radius;
    end
  end

  // Whole-pipeline advance: move whenever the output slot is free or taken.
  logic                res_v;
  logic                res_hit;
  logic [DIST_W-1:0]   res_dist;
  assign en        = !res_v || result.ready;
  assign ray.ready = en;

  // Stage 0: heading magnitudes and squares, center minus origin.
  logic signed [COORD_W-1:0] h_in [3];
  logic signed [COORD_W-1:0] o_in [3];
  logic signed [COORD_W-1:0] c_in [3];
  assign h_in[0] = ray.heading_x;
  assign h_in[1] = ray.heading_y;
  assign h_in[2] = ray.heading_z;
  assign o_in[0] = ray.origin_x;
  assign o_in[1] = ray.origin_y;
  assign o_in[2] = ray.origin_z;
  assign c_in[0] = ray.center_x;
  assign c_in[1] = ray.center_y;
  assign c_in[2] = ray.center_z;

  logic [2:0][COORD_W-1:0] hmag_c;
  logic [2:0]              hneg_c;
  logic [2:0][DIFF_W-1:0]  l_c;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hneg_c[j] = h_in[j][COORD_W-1];
      hmag_c[j] = hneg_c[j] ? COORD_W'(-h_in[j]) : COORD_W'(h_in[j]);
      l_c[j]    = DIFF_W'(DIFF_W'(c_in[j]) - DIFF_W'(o_in[j]));
    end
  end

  logic                 v0;
  logic [SUMSQ_W-1:0]   hsq0 [3];
  front_t               f0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= ray.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        hsq0[j] <= hmag_c[j] * hmag_c[j];
      end
      f0.l    <= l_c;
      f0.hmag <= hmag_c;
      f0.hneg <= hneg_c;
      f0.lim  <= ray.reach_limit;
    end
  end

  // Stage 1: squared heading length.
  logic               v1;
  logic [SUMSQ_W-1:0] sumsq1;
  front_t             f1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sumsq1 <= hsq0[0] + hsq0[1] + hsq0[2];
      f1     <= f0;
    end
  end

  // Heading length by pipelined square root.
  logic             v2;
  logic [LEN_W-1:0] len2;
  front_t           f2;
  rsi_isqrt #(.IN_W(SUMSQ_W), .PAY_W($bits(front_t))) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .radicand  (sumsq1),
    .in_pay    (f1),
    .out_valid (v2),
    .root      (len2),
    .out_pay   (f2)
  );

  // Normalize the heading; a too-short heading is flagged and ends as no hit.
  mid_t                     m2;
  logic                     vn;
  logic signed [FRAC_BITS+1:0] dirn [3];
  mid_t                     mn;
  assign m2.l         = f2.l;
  assign m2.lim       = f2.lim;
  assign m2.short_dir = len2 < MIN_LEN;

  rsi_norm #(.F(FRAC_BITS), .PAY_W($bits(mid_t))) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .len       (len2),
    .hmag      (f2.hmag),
    .hneg      (f2.hneg),
    .in_pay    (m2),
    .out_valid (vn),
    .dir       (dirn),
    .out_pay   (mn)
  );

  // Stage 3: projection terms and squared center distance terms.
  logic                     v3;
  logic signed [PROD_W-1:0] prod3 [3];
  logic [LSQ_W-1:0]         lsq3 [3];
  logic                     noline3;
  logic [DIST_W-1:0]        lim3;
  logic [DIFF_W-1:0]        lmag_c [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lmag_c[j] = mn.l[j][DIFF_W-1] ? DIFF_W'(-$signed(mn.l[j])) : mn.l[j];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vn;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        prod3[j] <= $signed(mn.l[j]) * dirn[j];
        lsq3[j]  <= lmag_c[j] * lmag_c[j];
      end
      noline3 <= mn.short_dir;
      lim3    <= mn.lim;
    end
  end

  // Stage 4: sum the projection; a negative one means the sphere is behind.
  logic signed [PROJ_W-1:0] proj_c;
  assign proj_c = PROJ_W'(prod3[0]) + PROJ_W'(prod3[1]) + PROJ_W'(prod3[2]);

  logic              v4;
  logic [TCA_W-1:0]  tca4;
  logic [LL_W-1:0]   ll4;
  logic              noline4;
  logic [DIST_W-1:0] lim4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tca4    <= proj_c[FRAC_BITS +: TCA_W];
      ll4     <= LL_W'(lsq3[0]) + LL_W'(lsq3[1]) + LL_W'(lsq3[2]);
      noline4 <= noline3 || proj_c[PROJ_W-1];
      lim4    <= lim3;
    end
  end

  // Stage 5: squared projection and squared radius.
  logic              v5;
  logic [ARG_W-1:0]  tt5;
  logic [R2_W-1:0]   r25;
  logic [TCA_W-1:0]  tca5;
  logic [LL_W-1:0]   ll5;
  logic              noline5;
  logic [DIST_W-1:0] lim5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tt5     <= tca4 * tca4;
      r25     <= radius * radius;
      tca5    <= tca4;
      ll5     <= ll4;
      noline5 <= noline4;
      lim5    <= lim4;
    end
  end

  // Stage 6: line test and the half-chord radicand r2 - d2.
  logic [ARG_W:0] rhs_c;
  logic [ARG_W:0] llx_c;
  assign rhs_c = {1'b0, tt5} + (ARG_W+1)'(r25);
  assign llx_c = (ARG_W+1)'(ll5);

  logic             v6;
  logic [ARG_W-1:0] arg6;
  back_t            b6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      arg6      <= ARG_W'(rhs_c - llx_c);
      b6.tca    <= tca5;
      b6.noline <= noline5 || (llx_c > rhs_c);
      b6.lim    <= lim5;
    end
  end

  // Half-chord length by pipelined square root.
  logic             v7;
  logic [TCA_W-1:0] thc7;
  back_t            b7;
  rsi_isqrt #(.IN_W(ARG_W), .PAY_W($bits(back_t))) u_chord_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .radicand  (arg6),
    .in_pay    (b6),
    .out_valid (v7),
    .root      (thc7),
    .out_pay   (b7)
  );

  // Root choice: near root unless the origin lies inside, then the far one.
  logic [TCA_W:0] root_c;
  always_comb begin
    if (b7.tca >= thc7) begin
      root_c = {1'b0, b7.tca} - {1'b0, thc7};
    end else begin
      root_c = {1'b0, b7.tca} + {1'b0, thc7};
    end
  end

  // Output register holding one result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (en) begin
      res_v <= v7;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_hit <= !b7.noline && (root_c <= (TCA_W+1)'(b7.lim));
      if (b7.noline) begin
        res_dist <= '0;
      end else if (root_c > (TCA_W+1)'(DIST_MAX)) begin
        res_dist <= DIST_MAX;
      end else begin
        res_dist <= root_c[DIST_W-1:0];
      end
    end
  end

  assign result.valid        = res_v;
  assign result.hit          = res_hit;
  assign result.hit_distance = res_dist;

  // A stall freezes the front of the pipeline.
  `RSI_ASSERT_NXT(a_stall_holds_front, clk, rst, !en, $stable(v0) && $stable(v1))
  // A ray that fails the line test leaves as a zero miss.
  `RSI_ASSERT_NXT(a_noline_zero, clk, rst, en && v7 && b7.noline,
                  result.valid && !result.hit && result.hit_distance == '0)
  // With the origin inside, the far root is strictly positive.
  `RSI_ASSERT_NXT(a_far_root_nonzero, clk, rst, en && v7 && !b7.noline && thc7 > b7.tca,
                  result.valid && result.hit_distance != '0)

endmodule
